// ===== hw/rtl/msss_pkg.sv =====
// ----------------------------------------------------------------------------
// msss_pkg
// Shared types and constants for the multi-stack shared store.
// ----------------------------------------------------------------------------
package msss_pkg;

  // Default configuration
  localparam int NUM_STACKS_DEF  = 4;
  localparam int STORE_DEPTH_DEF = 64;

  // Fixed field widths
  localparam int VALUE_W  = 32;
  localparam int SID_IN_W = 2;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

  // Control sequencer
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

// ===== hw/rtl/msss_in_if.sv =====
// ----------------------------------------------------------------------------
// msss_in_if
// Request channel: operation, stack number and push word.
// ----------------------------------------------------------------------------
interface msss_in_if;
  import msss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic [SID_IN_W-1:0]        stack_id;
  logic signed [VALUE_W-1:0]  push_value;

  modport source (output valid, output cmd, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input cmd, input stack_id, input push_value,
                  output ready);
endinterface

// ===== hw/rtl/msss_out_if.sv =====
// ----------------------------------------------------------------------------
// msss_out_if
// Result channel: status and popped word.
// ----------------------------------------------------------------------------
interface msss_out_if;
  import msss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

// ===== hw/rtl/multi_stack_shared_store_top.sv =====
// ----------------------------------------------------------------------------
// multi_stack_shared_store_top
// Several stacks threaded through one data store and one link store.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in ST_IDLE and completed in ST_EXEC;
//   no new request is taken before that, as the link RAM read must return
//   before the stack top and free list head can be updated; a result held
//   by a low out ready stalls the next request.
// Reset: all stacks empty, recycled list empty, fresh-slot count at zero.
//   Untouched slots go out in order by the fresh count; no clearing pass.
module multi_stack_shared_store_top #(
  parameter int NUM_STACKS  = msss_pkg::NUM_STACKS_DEF,
  parameter int STORE_DEPTH = msss_pkg::STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  msss_in_if.sink    in_chan,
  msss_out_if.source out_chan
);

  import msss_pkg::*;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int LINK_W = $clog2(STORE_DEPTH + 1);
  localparam int SID_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(STORE_DEPTH);

  // Control state
  state_t              state_r, state_nxt;
  logic [LINK_W-1:0]   top_r [NUM_STACKS];
  logic [LINK_W-1:0]   top_nxt [NUM_STACKS];
  logic [LINK_W-1:0]   rec_head_r, rec_head_nxt;
  logic [LINK_W-1:0]   fresh_r, fresh_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Per-request context
  logic                cmd_r, cmd_nxt;
  logic [SID_W-1:0]    sid_r, sid_nxt;
  logic                op_ok_r, op_ok_nxt;
  logic                from_rec_r, from_rec_nxt;
  logic [ADDR_W-1:0]   slot_r, slot_nxt;

  // Result payload
  logic [STATUS_W-1:0]       out_status_r, out_status_nxt;
  logic signed [VALUE_W-1:0] out_pop_value_r, out_pop_value_nxt;

  // Request decode
  logic                accept;
  logic                sid_ok;
  logic [SID_W-1:0]    sid_idx;
  logic [LINK_W-1:0]   cur_top;
  logic                rec_ok;
  logic                fresh_ok;
  logic                push_ok;
  logic                pop_ok;
  logic                exec_go;

  // RAM ports
  logic                data_wr_en, data_rd_en;
  logic [ADDR_W-1:0]   data_wr_addr, data_rd_addr;
  logic [VALUE_W-1:0]  data_rd_data;
  logic                link_wr_en, link_rd_en;
  logic [ADDR_W-1:0]   link_wr_addr, link_rd_addr;
  logic [LINK_W-1:0]   link_wr_data, link_rd_data;

  // Handshake
  assign in_chan.ready      = (state_r == ST_IDLE);
  assign accept             = in_chan.valid && in_chan.ready;
  assign exec_go            = (state_r == ST_EXEC) && (!out_valid_r || out_chan.ready);
  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.pop_value = out_pop_value_r;

  // Decode against current state
  assign sid_ok   = (32'(in_chan.stack_id) < 32'(NUM_STACKS));
  assign sid_idx  = SID_W'({{SID_W{1'b0}}, in_chan.stack_id});
  assign cur_top  = sid_ok ? top_r[sid_idx] : LINK_NULL;
  assign rec_ok   = (rec_head_r < LINK_NULL);
  assign fresh_ok = (fresh_r < LINK_NULL);
  assign push_ok  = sid_ok && (rec_ok || fresh_ok);
  assign pop_ok   = (cur_top < LINK_NULL);

  // Memory access at accept: push writes data, pop reads data and link,
  // a push from the recycled list reads the link to find the next head
  assign data_wr_en   = accept && (in_chan.cmd == CMD_PUSH) && push_ok;
  assign data_wr_addr = rec_ok ? ADDR_W'(rec_head_r) : ADDR_W'(fresh_r);
  assign data_rd_en   = accept && (in_chan.cmd == CMD_POP) && pop_ok;
  assign data_rd_addr = ADDR_W'(cur_top);

  assign link_rd_en   = accept && (((in_chan.cmd == CMD_POP) && pop_ok) ||
                                   ((in_chan.cmd == CMD_PUSH) && push_ok && rec_ok));
  assign link_rd_addr = (in_chan.cmd == CMD_POP) ? ADDR_W'(cur_top)
                                                 : ADDR_W'(rec_head_r);

  // Link write-back in the execute cycle
  assign link_wr_en   = exec_go && op_ok_r;
  assign link_wr_addr = slot_r;
  assign link_wr_data = (cmd_r == CMD_POP) ? rec_head_r : top_r[sid_r];

  // Next state and updates
  always_comb begin
    state_nxt         = state_r;
    top_nxt           = top_r;
    rec_head_nxt      = rec_head_r;
    fresh_nxt         = fresh_r;
    out_valid_nxt     = out_valid_r && !out_chan.ready;
    cmd_nxt           = cmd_r;
    sid_nxt           = sid_r;
    op_ok_nxt         = op_ok_r;
    from_rec_nxt      = from_rec_r;
    slot_nxt          = slot_r;
    out_status_nxt    = out_status_r;
    out_pop_value_nxt = out_pop_value_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_chan.cmd;
          sid_nxt      = sid_idx;
          from_rec_nxt = rec_ok;
          if (in_chan.cmd == CMD_PUSH) begin
            op_ok_nxt = push_ok;
            slot_nxt  = data_wr_addr;
            if (push_ok && !rec_ok) begin
              fresh_nxt = fresh_r + LINK_W'(1);
            end
          end else begin
            op_ok_nxt = pop_ok;
            slot_nxt  = ADDR_W'(cur_top);
          end
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          out_valid_nxt     = 1'b1;
          out_pop_value_nxt = '0;
          if (cmd_r == CMD_PUSH) begin
            if (op_ok_r) begin
              // pushed slot becomes the new top
              out_status_nxt = STAT_OK;
              top_nxt[sid_r] = LINK_W'(slot_r);
              if (from_rec_r) begin
                rec_head_nxt = link_rd_data;
              end
            end else begin
              out_status_nxt = STAT_OVERFLOW;
            end
          end else begin
            if (op_ok_r) begin
              // unlink top, recycle its slot
              out_status_nxt    = STAT_OK;
              out_pop_value_nxt = $signed(data_rd_data);
              top_nxt[sid_r]    = link_rd_data;
              rec_head_nxt      = LINK_W'(slot_r);
            end else begin
              out_status_nxt = STAT_UNDERFLOW;
            end
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rec_head_r  <= LINK_NULL;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        top_r[i] <= LINK_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      rec_head_r  <= rec_head_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
      top_r       <= top_nxt;
    end
  end

  // Context and payload registers
  always_ff @(posedge clk) begin
    cmd_r           <= cmd_nxt;
    sid_r           <= sid_nxt;
    op_ok_r         <= op_ok_nxt;
    from_rec_r      <= from_rec_nxt;
    slot_r          <= slot_nxt;
    out_status_r    <= out_status_nxt;
    out_pop_value_r <= out_pop_value_nxt;
  end

  // Slot data store
  msss_ram #(
    .WIDTH  (VALUE_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_wr_en),
    .wr_addr (data_wr_addr),
    .wr_data (VALUE_W'(in_chan.push_value)),
    .rd_en   (data_rd_en),
    .rd_addr (data_rd_addr),
    .rd_data (data_rd_data)
  );

  // Slot link store
  msss_ram #(
    .WIDTH  (LINK_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data)
  );

endmodule

// ===== hw/rtl/msss_ram.sv =====
// ----------------------------------------------------------------------------
// msss_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module msss_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
